[rtl/core/gdd_pkg.sv]
// Shared types, widths and calendar tables for the Gregorian date difference block.
package gdd_pkg;

    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 14;
    localparam int COUNT_W    = 23;
    localparam int DAYNUM_W   = 22;
    localparam int PREFIX_W   = 9;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 1;

    // Reciprocal of 100 scaled by 2^19; exact floor for any 14-bit operand.
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;

    localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;

    typedef struct packed {
        logic s1;
        logic s2;
    } gdd_lane_en_t;

    typedef struct packed {
        logic [DAYNUM_W-1:0] base;
        logic [PREFIX_W-1:0] dm;
        logic                ok;
    } gdd_lane_out_t;

    // Days in the months before the given one, common year.
    function automatic logic [PREFIX_W-1:0] month_prefix(input logic [MONTH_W-1:0] m);
        logic [PREFIX_W-1:0] p;
        case (m)
            4'd1:    p = 9'd0;
            4'd2:    p = 9'd31;
            4'd3:    p = 9'd59;
            4'd4:    p = 9'd90;
            4'd5:    p = 9'd120;
            4'd6:    p = 9'd151;
            4'd7:    p = 9'd181;
            4'd8:    p = 9'd212;
            4'd9:    p = 9'd243;
            4'd10:   p = 9'd273;
            4'd11:   p = 9'd304;
            4'd12:   p = 9'd334;
            default: p = 9'd0;
        endcase
        return p;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] l;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     l = 5'd30;
            4'd2:    l = leap ? 5'd29 : 5'd28;
            default: l = 5'd0;
        endcase
        return l;
    endfunction

endpackage

[rtl/core/gdd_lane.sv]
// One date lane: validity check and day number split into year base and in-year days.
module gdd_lane
(
    input  logic                          clk,
    input  gdd_pkg::gdd_lane_en_t         en,
    input  logic [gdd_pkg::DAY_W-1:0]     day,
    input  logic [gdd_pkg::MONTH_W-1:0]   month,
    input  logic [gdd_pkg::YEAR_W-1:0]    year,
    output gdd_pkg::gdd_lane_out_t        result
);
    import gdd_pkg::*;

    // Stage 1: products for whole years and the divisions by 100.
    logic [DAY_W-1:0]    day_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [YEAR_W-1:0]   py_reg;
    logic [DAYNUM_W-1:0] p365_reg;
    logic [QUOT_W-1:0]   qy_reg;
    logic [QUOT_W-1:0]   qp_reg;

    logic [YEAR_W-1:0]   py;
    logic [COUNT_W-1:0]  p365_full;
    logic [PROD_W-1:0]   qy_prod;
    logic [PROD_W-1:0]   qp_prod;

    assign py        = year - YEAR_MIN;
    assign p365_full = {{(COUNT_W-YEAR_W){1'b0}}, py} * {{(COUNT_W-9){1'b0}}, DAYS_COMMON_YEAR};
    assign qy_prod   = {{RECIP_W{1'b0}}, year} * {{YEAR_W{1'b0}}, RECIP_100};
    assign qp_prod   = {{RECIP_W{1'b0}}, py} * {{YEAR_W{1'b0}}, RECIP_100};

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            day_reg   <= day;
            month_reg <= month;
            year_reg  <= year;
            py_reg    <= py;
            p365_reg  <= p365_full[DAYNUM_W-1:0];
            qy_reg    <= qy_prod[PROD_W-1:RECIP_SHIFT];
            qp_reg    <= qp_prod[PROD_W-1:RECIP_SHIFT];
        end
    end

    // Stage 2: leap year, validity, year base and days within the year.
    logic [YEAR_W-1:0]   hundreds;
    logic [YEAR_W-1:0]   rem100;
    logic                leap;
    logic                month_ok;
    logic                year_ok;
    logic                day_ok;
    logic [DAYNUM_W-1:0] base_next;
    logic [PREFIX_W-1:0] dm_next;
    gdd_lane_out_t       result_reg;

    always_comb
    begin
        hundreds = {{(YEAR_W-QUOT_W){1'b0}}, qy_reg} * 14'd100;
        rem100   = year_reg - hundreds;
        // Divisible by 400 means divisible by 100 with a quotient divisible by 4.
        leap     = (year_reg[1:0] == 2'b00) && ((rem100 != '0) || (qy_reg[1:0] == 2'b00));
        month_ok = month_reg inside {[MONTH_JAN:MONTH_DEC]};
        year_ok  = year_reg inside {[YEAR_MIN:YEAR_MAX]};
        day_ok   = (day_reg != '0) && (day_reg <= month_len(month_reg, leap));
        base_next = p365_reg
                  + {{(DAYNUM_W-YEAR_W+2){1'b0}}, py_reg[YEAR_W-1:2]}
                  - {{(DAYNUM_W-QUOT_W){1'b0}}, qp_reg}
                  + {{(DAYNUM_W-QUOT_W+2){1'b0}}, qp_reg[QUOT_W-1:2]};
        dm_next  = month_prefix(month_reg)
                 + {{(PREFIX_W-1){1'b0}}, (leap && (month_reg > MONTH_FEB))}
                 + {{(PREFIX_W-DAY_W){1'b0}}, day_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            result_reg.base <= base_next;
            result_reg.dm   <= dm_next;
            result_reg.ok   <= month_ok && year_ok && day_ok;
        end
    end

    assign result = result_reg;

endmodule

[rtl/core/gdd_merge.sv]
// Merge stage: subtracts the start day number from the end day number and flags bad dates.
module gdd_merge
(
    input  logic                          clk,
    input  logic                          en,
    input  gdd_pkg::gdd_lane_out_t        start_lane,
    input  gdd_pkg::gdd_lane_out_t        end_lane,
    output logic [gdd_pkg::COUNT_W-1:0]   day_count,
    output logic                          date_invalid
);
    import gdd_pkg::*;

    logic [COUNT_W-1:0] day_count_reg;
    logic               date_invalid_reg;
    logic [COUNT_W-1:0] diff;
    logic               valid_pair;

    always_comb
    begin
        diff = ({1'b0, end_lane.base} + {{(COUNT_W-PREFIX_W){1'b0}}, end_lane.dm})
             - ({1'b0, start_lane.base} + {{(COUNT_W-PREFIX_W){1'b0}}, start_lane.dm});
        valid_pair = start_lane.ok && end_lane.ok;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            day_count_reg    <= valid_pair ? diff : '0;
            date_invalid_reg <= !valid_pair;
        end
    end

    assign day_count    = day_count_reg;
    assign date_invalid = date_invalid_reg;

endmodule

[rtl/core/gregorian_date_difference_top.sv]
// Top level of the Gregorian date difference block: handshake control, two lanes, merge.
//
// Usage: each beat on the slave channel carries a start date and an end date
// (day, month, year). Each beat on the master channel carries the signed day
// count, end minus start, in tdata and the invalid-date flag in tuser. A date
// with a day, month or year out of range sets the flag and forces the count
// to zero.
//
// An accepted input beat passes through three registered stages in order (lane
// multiply stage, lane table and sum stage, merge subtract stage) to the output.
// Throughput is one date pair per cycle while m_tready stays high; the stages
// are fully overlapped, and a stage holds its item only while the receiver stalls.
//
// When the receiver stalls, the output beat holds and the stages behind it
// keep filling until each holds an item; s_tready drops only when all three
// stages are occupied, so input beats are taken while a result waits.
// Reset clears every stage valid bit; no output beat is presented until an
// input beat has passed through the pipeline.
module gregorian_date_difference_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_day, start_month, start_year, end_day, end_month, end_year, zero pad
    input  logic [gdd_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // day_count, zero pad
    output logic [gdd_pkg::OUT_DATA_W-1:0]     m_tdata,
    // date_invalid
    output logic [gdd_pkg::OUT_USER_W-1:0]     m_tuser
);
    import gdd_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic s_fire;
    gdd_lane_en_t  lane_en;
    gdd_lane_out_t start_res;
    gdd_lane_out_t end_res;
    logic [COUNT_W-1:0] day_count;
    logic               date_invalid;

    assign rdy3   = !v3_reg || m_tready;
    assign rdy2   = !v2_reg || rdy3;
    assign rdy1   = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign s_fire = s_tvalid && rdy1;

    assign lane_en.s1 = rdy1;
    assign lane_en.s2 = rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    gdd_lane u_start_lane
    (
        .clk    (clk),
        .en     (lane_en),
        .day    (s_tdata[4:0]),
        .month  (s_tdata[8:5]),
        .year   (s_tdata[22:9]),
        .result (start_res)
    );

    gdd_lane u_end_lane
    (
        .clk    (clk),
        .en     (lane_en),
        .day    (s_tdata[27:23]),
        .month  (s_tdata[31:28]),
        .year   (s_tdata[45:32]),
        .result (end_res)
    );

    gdd_merge u_merge
    (
        .clk          (clk),
        .en           (rdy3),
        .start_lane   (start_res),
        .end_lane     (end_res),
        .day_count    (day_count),
        .date_invalid (date_invalid)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {{(OUT_DATA_W-COUNT_W){1'b0}}, day_count};
    assign m_tuser  = date_invalid;

    // A flagged result always carries a zero count.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[COUNT_W-1:0] == '0))
        else $error("invalid date pair produced a nonzero count");

    // The count stays within the span of years 1 to 9999.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (($signed(m_tdata[COUNT_W-1:0]) <= 23'sd3652059) &&
                      ($signed(m_tdata[COUNT_W-1:0]) >= -23'sd3652059)))
        else $error("day count outside the calendar range");

    // Input is refused only when every stage holds an item.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && !m_tready))
        else $error("input refused with room in the pipeline");

    // An accepted beat reaches the first stage.
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> v1_reg)
        else $error("accepted beat lost at the first stage");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the Gregorian date difference stream block.
`timescale 1ns / 100ps

module tb_top;

    localparam int IN_W   = gdd_pkg::IN_DATA_W;
    localparam int N_RAND = 2000;

    // Keeps the day counts predicted for accepted date pairs and checks the results.
    class date_diff_board;
        localparam int SM_LSB = gdd_pkg::DAY_W;
        localparam int SY_LSB = SM_LSB + gdd_pkg::MONTH_W;
        localparam int ED_LSB = SY_LSB + gdd_pkg::YEAR_W;
        localparam int EM_LSB = ED_LSB + gdd_pkg::DAY_W;
        localparam int EY_LSB = EM_LSB + gdd_pkg::MONTH_W;

        typedef struct packed {
            logic [gdd_pkg::COUNT_W-1:0] day_count;
            logic                        date_invalid;
        } diff_result_t;

        diff_result_t awaited_q[$];
        int unsigned  mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function logic [IN_W-1:0] pack_pair(int unsigned sd, int unsigned sm,
                                                   int unsigned sy, int unsigned ed,
                                                   int unsigned em, int unsigned ey);
            logic [IN_W-1:0] d;
            d = '0;
            d[SM_LSB-1:0]      = sd[gdd_pkg::DAY_W-1:0];
            d[SY_LSB-1:SM_LSB] = sm[gdd_pkg::MONTH_W-1:0];
            d[ED_LSB-1:SY_LSB] = sy[gdd_pkg::YEAR_W-1:0];
            d[EM_LSB-1:ED_LSB] = ed[gdd_pkg::DAY_W-1:0];
            d[EY_LSB-1:EM_LSB] = em[gdd_pkg::MONTH_W-1:0];
            d[IN_W-3:EY_LSB]   = ey[gdd_pkg::YEAR_W-1:0];
            return d;
        endfunction

        static function bit leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int unsigned days_in_month(int unsigned m, bit leap);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        static function bit real_date(int unsigned d, int unsigned m, int unsigned y);
            if (m < 1 || m > 12 || y < 1 || y > 9999)
                return 0;
            return d >= 1 && d <= days_in_month(m, leap_year(y));
        endfunction

        // Day 1 is 0001-01-01.
        static function int unsigned serial_day(int unsigned d, int unsigned m,
                                                int unsigned y);
            int unsigned py;
            int unsigned n;
            py = y - 1;
            n  = py * 365 + py / 4 - py / 100 + py / 400;
            for (int unsigned i = 1; i < m; i++)
                n += days_in_month(i, leap_year(y));
            return n + d;
        endfunction

        function void note_pair(logic [IN_W-1:0] d);
            int unsigned  sd, sm, sy, ed, em, ey;
            int           span;
            diff_result_t r;
            sd = d[SM_LSB-1:0];
            sm = d[SY_LSB-1:SM_LSB];
            sy = d[ED_LSB-1:SY_LSB];
            ed = d[EM_LSB-1:ED_LSB];
            em = d[EY_LSB-1:EM_LSB];
            ey = d[IN_W-3:EY_LSB];
            span = 0;
            r.date_invalid = 1'b1;
            if (real_date(sd, sm, sy) && real_date(ed, em, ey)) begin
                span = int'(serial_day(ed, em, ey)) - int'(serial_day(sd, sm, sy));
                r.date_invalid = 1'b0;
            end
            r.day_count = span[gdd_pkg::COUNT_W-1:0];
            awaited_q.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(logic [gdd_pkg::OUT_DATA_W-1:0] data,
                          logic [gdd_pkg::OUT_USER_W-1:0] user);
            diff_result_t want;
            if (awaited_q.size() == 0) begin
                report_mismatch("unexpected beat, day_count", int'($signed(
                    data[gdd_pkg::COUNT_W-1:0])), 0);
                return;
            end
            want = awaited_q.pop_front();
            if (data[gdd_pkg::COUNT_W-1:0] !== want.day_count)
                report_mismatch("day_count", int'($signed(data[gdd_pkg::COUNT_W-1:0])),
                                int'($signed(want.day_count)));
            if (user[0] !== want.date_invalid)
                report_mismatch("date_invalid", int'(user[0]), int'(want.date_invalid));
        endtask
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [IN_W-1:0]                  s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [gdd_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic [gdd_pkg::OUT_USER_W-1:0]   m_tuser;

    int unsigned    send_idle_pct;
    int unsigned    recv_stall_pct;
    date_diff_board board;

    gregorian_date_difference_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(negedge clk)
    begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_pair(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    // Holds one beat on the slave side until the block takes it.
    task send_pair(logic [IN_W-1:0] d);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task send_dates(int unsigned sd, int unsigned sm, int unsigned sy,
                    int unsigned ed, int unsigned em, int unsigned ey);
        send_pair(date_diff_board::pack_pair(sd, sm, sy, ed, em, ey));
    endtask

    // Century and quad-century years are weighted up so the leap rule is exercised.
    function automatic int unsigned pick_year();
        case ($urandom_range(5))
            0:       return 100 * $urandom_range(99, 1);
            1:       return 400 * $urandom_range(24, 1);
            2:       return 4 * $urandom_range(2499, 1);
            3:       return $urandom_range(1) ? $urandom_range(5, 1) : $urandom_range(9999, 9994);
            default: return $urandom_range(9999, 1);
        endcase
    endfunction

    task send_random_pair();
        int unsigned sd, sm, sy, ed, em, ey;
        int          near;
        int unsigned kind;
        kind = $urandom_range(99);
        sy = pick_year();
        case ($urandom_range(9))
            0, 1, 2:    ey = sy;
            3, 4, 5:
            begin
                near = int'(sy) + $urandom_range(6) - 3;
                ey = (near < 1) ? 1 : (near > 9999) ? 9999 : near;
            end
            default:    ey = pick_year();
        endcase
        sm = $urandom_range(12, 1);
        em = $urandom_range(12, 1);
        sd = $urandom_range(date_diff_board::days_in_month(sm, date_diff_board::leap_year(sy)), 1);
        ed = $urandom_range(date_diff_board::days_in_month(em, date_diff_board::leap_year(ey)), 1);
        if (kind >= 94)
        begin
            sd = $urandom_range(31);
            sm = $urandom_range(15);
            sy = $urandom_range(16383);
            ed = $urandom_range(31);
            em = $urandom_range(15);
            ey = $urandom_range(16383);
        end
        else if (kind >= 85)
        begin
            // Break one field of an otherwise sound pair.
            case ($urandom_range(5))
                0:       sd = $urandom_range(31);
                1:       sm = $urandom_range(15);
                2:       sy = $urandom_range(16383);
                3:       ed = $urandom_range(31);
                4:       em = $urandom_range(15);
                default: ey = $urandom_range(16383);
            endcase
        end
        send_dates(sd, sm, sy, ed, em, ey);
    endtask

    initial
    begin
        board          = new();
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_dates(1, 1, 1, 1, 1, 1);
        send_dates(1, 1, 1, 31, 12, 9999);
        send_dates(31, 12, 9999, 1, 1, 1);
        send_dates(15, 6, 2024, 15, 6, 2024);
        send_dates(20, 11, 2023, 3, 2, 2023);
        send_dates(31, 12, 1999, 1, 1, 2000);
        send_dates(29, 2, 2000, 1, 3, 2000);
        send_dates(28, 2, 1900, 29, 2, 1900);
        send_dates(1, 1, 2024, 29, 2, 2024);
        send_dates(29, 2, 2023, 1, 3, 2023);
        send_dates(0, 5, 2010, 1, 5, 2010);
        send_dates(1, 5, 2010, 31, 4, 2010);
        send_dates(31, 1, 100, 31, 12, 400);
        send_dates(1, 0, 1500, 1, 1, 1500);
        send_dates(1, 1, 1500, 1, 13, 1500);
        send_dates(1, 15, 1500, 1, 1, 1500);
        send_dates(1, 1, 0, 1, 1, 1);
        send_dates(1, 1, 1, 1, 1, 10000);
        send_dates(1, 1, 16383, 1, 1, 16383);
        send_dates(31, 15, 16383, 31, 15, 16383);
        send_dates(1, 3, 1600, 28, 2, 1600);
        send_dates(7, 9, 5432, 12, 10, 1234);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            endcase
            repeat (N_RAND / 4)
                send_random_pair();
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (board.awaited_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
